[rtl/core/sbl_pkg.sv]
package sbl_pkg;

    // request codes carried by req_type
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_ARM   = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_SEND  = 2'd3;

    // completion codes carried by error_code
    localparam logic [1:0] ERR_PASS       = 2'd0;
    localparam logic [1:0] ERR_IDLE       = 2'd1;
    localparam logic [1:0] ERR_RX_ABORT   = 2'd2;
    localparam logic [1:0] ERR_TX_ABORT   = 2'd3;

    // fixed byte sent between the payload and the status byte
    localparam logic [7:0] TRAILER_BYTE = 8'h90;
    localparam logic [7:0] COUNT_EXTRA  = 8'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic       select_pin;
        logic       clock_pin;
        logic       data_in_pin;
        logic [7:0] tx_index;
        logic [7:0] tx_byte;
        logic [7:0] tx_count;
        logic [7:0] status_byte;
    } item_t;

    typedef struct packed {
        logic       data_out_pin;
        logic       busy_pin;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
        logic [7:0] rx_count;
        logic       done_res;
        logic [1:0] error_code;
    } res_t;

endpackage

[rtl/core/sbl_ram.sv]
module sbl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/sbl_engine.sv]
module sbl_engine #(
    parameter int unsigned TX_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  sbl_pkg::item_t item,
    output sbl_pkg::res_t  res
);

    import sbl_pkg::*;

    localparam int unsigned AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RX_LEN,
        PH_RX_DATA,
        PH_RX_EXEC,
        PH_TX_COUNT,
        PH_TX_DATA,
        PH_TX_90,
        PH_TX_STATUS
    } phase_t;

    phase_t     phase_reg,        phase_next;
    logic       wait_low_reg,     wait_low_next;
    logic [2:0] bit_cnt_reg,      bit_cnt_next;
    logic [7:0] shift_reg,        shift_next;
    logic [7:0] bytes_left_reg,   bytes_left_next;
    logic [7:0] send_pos_reg,     send_pos_next;
    logic [7:0] saved_count_reg,  saved_count_next;
    logic [7:0] saved_status_reg, saved_status_next;
    logic       miso_reg,         miso_next;
    logic       busy_reg,         busy_next;
    logic       fwd_hit_reg,      fwd_hit_next;
    logic [7:0] fwd_byte_reg;

    logic [AW-1:0] mod_tab [256];
    logic [7:0]    send_pos_d;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic          ram_we;
    logic [7:0]    ram_q;
    logic [7:0]    buf_byte;

    // slot of each byte index in a buffer of TX_DEPTH entries
    for (genvar g = 0; g < 256; g++)
    begin : g_mod
        localparam int unsigned MOD_G = g % TX_DEPTH;
        assign mod_tab[g] = AW'(MOD_G);
    end

    assign send_pos_d = fire ? send_pos_next : send_pos_reg;
    assign ram_waddr  = mod_tab[item.tx_index];
    assign ram_raddr  = mod_tab[send_pos_d];
    assign ram_we     = fire && (item.req_type == REQ_WRITE);
    assign fwd_hit_next = ram_we && (ram_waddr == ram_raddr);

    // read data always tracks the slot at the current send position
    assign buf_byte = fwd_hit_reg ? fwd_byte_reg : ram_q;

    sbl_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.tx_byte),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        logic bit_phase;
        logic rx_mode;
        logic handled;
        logic ev_abort;
        logic ev_byte;
        logic rx_ctx;
        logic [7:0] bl_dec;

        phase_next        = phase_reg;
        wait_low_next     = wait_low_reg;
        bit_cnt_next      = bit_cnt_reg;
        shift_next        = shift_reg;
        bytes_left_next   = bytes_left_reg;
        send_pos_next     = send_pos_reg;
        saved_count_next  = saved_count_reg;
        saved_status_next = saved_status_reg;
        miso_next         = miso_reg;
        busy_next         = busy_reg;

        res        = '0;
        rx_ctx     = 1'b0;
        handled    = 1'b0;
        ev_abort   = 1'b0;
        ev_byte    = 1'b0;
        bit_phase  = phase_reg inside {PH_RX_LEN, PH_RX_DATA, PH_TX_COUNT,
                                       PH_TX_DATA, PH_TX_90, PH_TX_STATUS};
        rx_mode    = phase_reg inside {PH_RX_LEN, PH_RX_DATA};
        bl_dec     = bytes_left_reg - 8'd1;

        // bit timing shared by receive and send
        if ((item.req_type == REQ_TICK) && bit_phase)
        begin
            if (!wait_low_reg)
            begin
                if (item.clock_pin)
                begin
                    if (rx_mode)
                    begin
                        shift_next = {item.data_in_pin, shift_reg[7:1]};
                    end
                    else
                    begin
                        miso_next  = shift_reg[0];
                        shift_next = {1'b0, shift_reg[7:1]};
                    end
                    busy_next     = 1'b1;
                    wait_low_next = 1'b1;
                    handled       = 1'b1;
                end
            end
            else if (!item.clock_pin)
            begin
                busy_next     = 1'b0;
                wait_low_next = 1'b0;
                handled       = 1'b1;
                if (bit_cnt_reg == 3'd7)
                begin
                    bit_cnt_next = 3'd0;
                    ev_byte      = 1'b1;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                end
            end
            if (!handled && !item.select_pin)
            begin
                wait_low_next = 1'b0;
                bit_cnt_next  = 3'd0;
                ev_abort      = 1'b1;
            end
        end

        case (item.req_type)
            REQ_ARM:
            begin
                busy_next        = 1'b0;
                wait_low_next    = 1'b0;
                bit_cnt_next     = 3'd0;
                saved_count_next = 8'd0;
                rx_ctx           = 1'b1;
                if (!item.select_pin)
                begin
                    phase_next     = PH_IDLE;
                    res.done_res   = 1'b1;
                    res.error_code = ERR_IDLE;
                end
                else
                begin
                    phase_next = PH_RX_LEN;
                end
            end
            REQ_WRITE:
            begin
                rx_ctx = phase_reg inside {PH_RX_LEN, PH_RX_DATA, PH_RX_EXEC};
            end
            REQ_SEND:
            begin
                busy_next         = 1'b0;
                wait_low_next     = 1'b0;
                bit_cnt_next      = 3'd0;
                send_pos_next     = 8'd0;
                bytes_left_next   = item.tx_count;
                saved_status_next = item.status_byte;
                shift_next        = item.tx_count + COUNT_EXTRA;
                phase_next        = PH_TX_COUNT;
            end
            default:
            begin
                case (phase_reg)
                    PH_RX_LEN, PH_RX_DATA:
                    begin
                        rx_ctx = 1'b1;
                        if (ev_abort)
                        begin
                            saved_count_next = 8'd0;
                            phase_next       = PH_IDLE;
                            res.done_res     = 1'b1;
                            res.error_code   = ERR_RX_ABORT;
                        end
                        else if (ev_byte)
                        begin
                            if (phase_reg == PH_RX_LEN)
                            begin
                                saved_count_next = shift_reg;
                                bytes_left_next  = shift_reg;
                                phase_next = (shift_reg == 8'd0) ? PH_RX_EXEC : PH_RX_DATA;
                            end
                            else
                            begin
                                res.rx_valid    = 1'b1;
                                res.rx_byte     = shift_reg;
                                bytes_left_next = bl_dec;
                                res.rx_last     = (bl_dec == 8'd0);
                                if (bl_dec == 8'd0)
                                begin
                                    phase_next = PH_RX_EXEC;
                                end
                            end
                        end
                    end
                    PH_RX_EXEC:
                    begin
                        rx_ctx = 1'b1;
                        if (!wait_low_reg && item.clock_pin)
                        begin
                            busy_next     = 1'b1;
                            wait_low_next = 1'b1;
                        end
                        else if (wait_low_reg && !item.clock_pin)
                        begin
                            wait_low_next = 1'b0;
                            phase_next    = PH_IDLE;
                            res.done_res  = 1'b1;
                        end
                        else if (!item.select_pin)
                        begin
                            wait_low_next  = 1'b0;
                            phase_next     = PH_IDLE;
                            res.done_res   = 1'b1;
                            res.error_code = ERR_RX_ABORT;
                        end
                    end
                    PH_TX_COUNT, PH_TX_DATA, PH_TX_90, PH_TX_STATUS:
                    begin
                        if (ev_abort)
                        begin
                            // trailer aborts are ignored
                            if (phase_reg == PH_TX_90)
                            begin
                                shift_next = saved_status_reg;
                                phase_next = PH_TX_STATUS;
                            end
                            else
                            begin
                                busy_next    = 1'b0;
                                miso_next    = 1'b0;
                                phase_next   = PH_IDLE;
                                res.done_res = 1'b1;
                                if (phase_reg != PH_TX_STATUS)
                                begin
                                    res.error_code = ERR_TX_ABORT;
                                end
                            end
                        end
                        else if (ev_byte)
                        begin
                            if ((phase_reg == PH_TX_COUNT) || (phase_reg == PH_TX_DATA))
                            begin
                                if (phase_reg == PH_TX_DATA)
                                begin
                                    bytes_left_next = bl_dec;
                                end
                                if (bytes_left_next == 8'd0)
                                begin
                                    shift_next = TRAILER_BYTE;
                                    phase_next = PH_TX_90;
                                end
                                else
                                begin
                                    shift_next    = buf_byte;
                                    send_pos_next = send_pos_reg + 8'd1;
                                    phase_next    = PH_TX_DATA;
                                end
                            end
                            else if (phase_reg == PH_TX_90)
                            begin
                                shift_next = saved_status_reg;
                                phase_next = PH_TX_STATUS;
                            end
                            else
                            begin
                                busy_next    = 1'b0;
                                miso_next    = 1'b0;
                                phase_next   = PH_IDLE;
                                res.done_res = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        rx_ctx = 1'b0;
                    end
                endcase
            end
        endcase

        res.data_out_pin = miso_next;
        res.busy_pin     = busy_next;
        res.rx_count     = rx_ctx ? saved_count_next : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            wait_low_reg     <= 1'b0;
            bit_cnt_reg      <= 3'd0;
            shift_reg        <= 8'd0;
            bytes_left_reg   <= 8'd0;
            send_pos_reg     <= 8'd0;
            saved_count_reg  <= 8'd0;
            saved_status_reg <= 8'd0;
            miso_reg         <= 1'b0;
            busy_reg         <= 1'b0;
            fwd_hit_reg      <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= fwd_hit_next;
            if (fire)
            begin
                phase_reg        <= phase_next;
                wait_low_reg     <= wait_low_next;
                bit_cnt_reg      <= bit_cnt_next;
                shift_reg        <= shift_next;
                bytes_left_reg   <= bytes_left_next;
                send_pos_reg     <= send_pos_next;
                saved_count_reg  <= saved_count_next;
                saved_status_reg <= saved_status_next;
                miso_reg         <= miso_next;
                busy_reg         <= busy_next;
            end
        end
    end

    // bypass for a write landing on the slot being read
    always_ff @(posedge clk)
    begin
        fwd_byte_reg <= item.tx_byte;
    end

`ifndef SYNTHESIS
    idle_bit_clear_a : assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (!wait_low_reg && (bit_cnt_reg == 3'd0)))
        else $error("bit timing left active while idle");

    master_idle_a : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.req_type == REQ_ARM) && !item.select_pin)
        |=> ((phase_reg == PH_IDLE) && !busy_reg))
        else $error("arm with select low did not return to idle");

    rx_word_phase_a : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.rx_valid) |-> (phase_reg == PH_RX_DATA))
        else $error("received word presented outside payload phase");

    err_needs_done_a : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (res.error_code != ERR_PASS)) |-> res.done_res)
        else $error("error code without completion");
`endif

endmodule

[rtl/core/spi_slave_busy_handshake_link_top.sv]
// serial slave link, lsb first, active-high select and a busy handshake line
// input channel: in_valid / in_stall carry one request word; req_type picks a
//   pin sample tick, arm receive, write of a transmit buffer byte or start send
// output channel: out_valid / out_stall return exactly one result word per
//   request word: driven data-out and busy levels, received word, completion
// a request accepted into the input register is handled by the engine and its
//   result is captured in the result register that drives out_valid
// throughput: one word per cycle while out_stall is low; the input register and result register
//   are separated, so a new word is taken while a finished result waits
// a stalled result holds in the result register; one more request word waits
//   in the input register and then in_stall rises until the result is taken
// the transmit buffer is a registered-read ram that always reads the slot at
//   the current send position, with a bypass for a write to that same slot
// reset clears phase, bit timing, counters and the pin registers; the buffer
//   holds no reset value and must be written before it is sent
module spi_slave_busy_handshake_link_top #(
    parameter int unsigned TX_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,

    // request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic       select_pin,
    input  logic       clock_pin,
    input  logic       data_in_pin,
    input  logic [7:0] tx_index,
    input  logic [7:0] tx_byte,
    input  logic [7:0] tx_count,
    input  logic [7:0] status_byte,

    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       data_out_pin,
    output logic       busy_pin,
    output logic       rx_valid,
    output logic [7:0] rx_byte,
    output logic       rx_last,
    output logic [7:0] rx_count,
    output logic       done_res,
    output logic [1:0] error_code
);

    import sbl_pkg::*;

    // input register
    logic  in_v_reg, in_v_next;
    item_t item_reg;

    // result register
    logic  out_v_reg, out_v_next;
    res_t  res_reg;
    res_t  res_comb;

    logic  fire;
    logic  in_take;

    // the engine works on the held word when the result slot is free or being taken
    assign fire     = in_v_reg && (!out_v_reg || !out_stall);
    assign in_stall = in_v_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    assign in_v_next  = in_take || (in_v_reg && !fire);
    assign out_v_next = fire || (out_v_reg && out_stall);

    sbl_engine #(
        .TX_DEPTH (TX_DEPTH)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .res   (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.req_type    <= req_type;
            item_reg.select_pin  <= select_pin;
            item_reg.clock_pin   <= clock_pin;
            item_reg.data_in_pin <= data_in_pin;
            item_reg.tx_index    <= tx_index;
            item_reg.tx_byte     <= tx_byte;
            item_reg.tx_count    <= tx_count;
            item_reg.status_byte <= status_byte;
        end
        if (fire)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid    = out_v_reg;
    assign data_out_pin = res_reg.data_out_pin;
    assign busy_pin     = res_reg.busy_pin;
    assign rx_valid     = res_reg.rx_valid;
    assign rx_byte      = res_reg.rx_byte;
    assign rx_last      = res_reg.rx_last;
    assign rx_count     = res_reg.rx_count;
    assign done_res     = res_reg.done_res;
    assign error_code   = res_reg.error_code;

endmodule
